[hdl/shared_timer_uart_transceiver_defines.svh]
// Assertion macros shared by the transceiver's checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SHARED_TIMER_UART_TRANSCEIVER_DEFINES_SVH
`define SHARED_TIMER_UART_TRANSCEIVER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define STUT_ASSERT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STUT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/stut_pkg.sv]
// Shared types and constants for the shared-timer UART transceiver.
// No dependencies; used by the top level and its checker.
package stut_pkg;

  localparam int unsigned TimerBits = 16;

  typedef logic [TimerBits-1:0] tick_t;

  // Register map, word index = paddr[3:2]
  typedef enum logic [1:0] {
    RegBitTime          = 2'd0,
    RegHalfBitTime      = 2'd1,
    RegQuarterBitTime   = 2'd2,
    RegThreeQuarterTime = 2'd3
  } reg_idx_e;

  localparam logic [15:0] BitTimeRst          = 16'd1667;
  localparam logic [14:0] HalfBitTimeRst      = 15'd833;
  localparam logic [13:0] QuarterBitTimeRst   = 14'd416;
  localparam logic [15:0] ThreeQuarterTimeRst = 16'd1250;

  // Frame counts: start bit at 9, data 8..1, stop at 0
  localparam logic [3:0] FrameStartCount = 4'd9;
  localparam logic [3:0] FrameStopCount  = 4'd0;

  localparam logic [7:0] LineFeed       = 8'd10;
  localparam logic [7:0] CarriageReturn = 8'd13;

endpackage

[hdl/shared_timer_uart_transceiver.sv]
// An accepted tick's line levels and received byte reach the output register in the
// cycle after acceptance. Throughput: one tick per cycle unless stalled, set by the
// single pass from state registers through compare/window logic back into state.
// A stalled result holds off input; a new tick enters in the cycle the old one leaves.
// Reset (rst_ni low, async): idle lines, timer stopped, registers at defaults.
// Depends on stut_pkg.
module shared_timer_uart_transceiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // tick input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        rxd_i,
  input  logic        tx_load_i,
  input  logic [7:0]  tx_data_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        txd_o,
  output logic        tx_busy_o,
  output logic        rx_busy_o,
  output logic        rx_valid_o,
  output logic [7:0]  rx_data_o,
  output logic        rx_end_of_line_o
);

  // configuration
  logic [15:0] bit_time_q;
  logic [14:0] half_bit_q;
  logic [13:0] quarter_bit_q;
  logic [15:0] three_quarter_q;

  // timer and protocol state
  stut_pkg::tick_t timer_q, timer_d;
  stut_pkg::tick_t cmp_q, cmp_d;
  logic        timer_en_q, timer_en_d;
  logic        rx_active_q, rx_active_d;
  logic        tx_active_q, tx_active_d;
  logic        in_phase_q, in_phase_d;
  logic        rx_turn_q, rx_turn_d;
  logic        tx_turn_q, tx_turn_d;
  logic [8:0]  rx_shift_q, rx_shift_d;
  logic [3:0]  rx_left_q, rx_left_d;
  logic [7:0]  tx_shift_q, tx_shift_d;
  logic [3:0]  tx_left_q, tx_left_d;
  logic        tx_line_q, tx_line_d;
  logic        armed_q, armed_d;
  logic        rxd_last_q, rxd_last_d;

  // per-tick temporaries
  stut_pkg::tick_t step, left;
  logic        fall;
  logic        got_byte;
  logic [7:0]  got_data;

  // output register
  logic        out_valid_q;
  logic        txd_q, tx_busy_q, rx_busy_q, rx_valid_q, eol_q;
  logic [7:0]  rx_data_q;

  logic        in_accept;
  logic        cfg_write;
  stut_pkg::reg_idx_e cfg_idx;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  assign pready    = 1'b1;
  assign cfg_idx   = stut_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      stut_pkg::RegBitTime:          prdata = {16'd0, bit_time_q};
      stut_pkg::RegHalfBitTime:      prdata = {17'd0, half_bit_q};
      stut_pkg::RegQuarterBitTime:   prdata = {18'd0, quarter_bit_q};
      stut_pkg::RegThreeQuarterTime: prdata = {16'd0, three_quarter_q};
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_time_q      <= stut_pkg::BitTimeRst;
      half_bit_q      <= stut_pkg::HalfBitTimeRst;
      quarter_bit_q   <= stut_pkg::QuarterBitTimeRst;
      three_quarter_q <= stut_pkg::ThreeQuarterTimeRst;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        stut_pkg::RegBitTime:          bit_time_q      <= pwdata[15:0];
        stut_pkg::RegHalfBitTime:      half_bit_q      <= pwdata[14:0];
        stut_pkg::RegQuarterBitTime:   quarter_bit_q   <= pwdata[13:0];
        stut_pkg::RegThreeQuarterTime: three_quarter_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // One tick: compare event, then receive edge, then transmit load, then count.
  always_comb begin
    timer_d     = timer_q;
    cmp_d       = cmp_q;
    timer_en_d  = timer_en_q;
    rx_active_d = rx_active_q;
    tx_active_d = tx_active_q;
    in_phase_d  = in_phase_q;
    rx_turn_d   = rx_turn_q;
    tx_turn_d   = tx_turn_q;
    rx_shift_d  = rx_shift_q;
    rx_left_d   = rx_left_q;
    tx_shift_d  = tx_shift_q;
    tx_left_d   = tx_left_q;
    tx_line_d   = tx_line_q;
    armed_d     = armed_q;
    step        = '0;
    left        = '0;
    got_byte    = 1'b0;
    got_data    = '0;

    if (timer_en_q && (timer_q == cmp_q)) begin
      step  = stut_pkg::TimerBits'(half_bit_q)
            + (in_phase_q ? stut_pkg::TimerBits'(half_bit_q) : '0);
      cmp_d = cmp_q + step;

      if (rx_active_q && rx_turn_q) begin
        rx_shift_d = {1'b0, rx_shift_q[8] | rxd_i, rx_shift_q[7:1]};
        rx_left_d  = rx_left_q - 4'd1;
        if (rx_left_d == '0) begin
          rx_active_d = 1'b0;
          got_byte    = 1'b1;
          got_data    = rx_shift_d[7:0];
          armed_d     = 1'b1;
          if (!tx_active_q) timer_en_d = 1'b0;
        end
      end

      if (tx_active_q && tx_turn_q) begin
        if (tx_left_q == stut_pkg::FrameStopCount) begin
          tx_line_d   = 1'b1;
          tx_active_d = 1'b0;
          if (!rx_active_d) timer_en_d = 1'b0;
        end else if (tx_left_q == stut_pkg::FrameStartCount) begin
          tx_line_d = 1'b0;
          tx_left_d = tx_left_q - 4'd1;
        end else begin
          tx_line_d  = tx_shift_q[0];
          tx_shift_d = {1'b0, tx_shift_q[7:1]};
          tx_left_d  = tx_left_q - 4'd1;
        end
      end

      if (!in_phase_q) begin
        rx_turn_d = !rx_turn_q;
        tx_turn_d = !tx_turn_q;
      end
    end

    fall       = rxd_last_q && !rxd_i;
    rxd_last_d = rxd_i;
    if (fall && armed_d) begin
      rx_active_d = 1'b1;
      in_phase_d  = 1'b1;
      rx_turn_d   = 1'b1;
      armed_d     = 1'b0;
      if (tx_active_d) begin
        // distance to the next compare decides whether rx can share it
        left = cmp_d - timer_q;
        if ((32'(left) < 32'(quarter_bit_q)) || (32'(left) > 32'(three_quarter_q))) begin
          in_phase_d = 1'b0;
          rx_turn_d  = 1'b0;
          tx_turn_d  = 1'b1;
        end
      end else begin
        cmp_d = timer_q + stut_pkg::TimerBits'(half_bit_q);
      end
      timer_en_d = 1'b1;
      rx_shift_d = '0;
      rx_left_d  = stut_pkg::FrameStartCount;
    end

    if (tx_load_i && !tx_active_d) begin
      tx_shift_d  = tx_data_i;
      tx_line_d   = 1'b1;
      tx_active_d = 1'b1;
      tx_left_d   = stut_pkg::FrameStartCount;
      if (rx_active_d && !in_phase_d) begin
        tx_turn_d = !rx_turn_d;
      end else begin
        in_phase_d = 1'b1;
        tx_turn_d  = 1'b1;
      end
      if (!rx_active_d) begin
        cmp_d      = timer_q + stut_pkg::TimerBits'(bit_time_q);
        timer_en_d = 1'b1;
      end
    end

    timer_d = timer_q + stut_pkg::TimerBits'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q     <= '0;
      cmp_q       <= '0;
      timer_en_q  <= 1'b0;
      rx_active_q <= 1'b0;
      tx_active_q <= 1'b0;
      in_phase_q  <= 1'b1;
      rx_turn_q   <= 1'b1;
      tx_turn_q   <= 1'b1;
      rx_shift_q  <= '0;
      rx_left_q   <= '0;
      tx_shift_q  <= '0;
      tx_left_q   <= '0;
      tx_line_q   <= 1'b1;
      armed_q     <= 1'b1;
      rxd_last_q  <= 1'b1;
    end else if (in_accept) begin
      timer_q     <= timer_d;
      cmp_q       <= cmp_d;
      timer_en_q  <= timer_en_d;
      rx_active_q <= rx_active_d;
      tx_active_q <= tx_active_d;
      in_phase_q  <= in_phase_d;
      rx_turn_q   <= rx_turn_d;
      tx_turn_q   <= tx_turn_d;
      rx_shift_q  <= rx_shift_d;
      rx_left_q   <= rx_left_d;
      tx_shift_q  <= tx_shift_d;
      tx_left_q   <= tx_left_d;
      tx_line_q   <= tx_line_d;
      armed_q     <= armed_d;
      rxd_last_q  <= rxd_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      txd_q      <= 1'b1;
      tx_busy_q  <= 1'b0;
      rx_busy_q  <= 1'b0;
      rx_valid_q <= 1'b0;
      rx_data_q  <= '0;
      eol_q      <= 1'b0;
    end else if (in_accept) begin
      txd_q      <= tx_line_d;
      tx_busy_q  <= tx_active_d;
      rx_busy_q  <= rx_active_d;
      rx_valid_q <= got_byte;
      rx_data_q  <= got_data;
      eol_q      <= got_byte && ((got_data == stut_pkg::LineFeed) ||
                                 (got_data == stut_pkg::CarriageReturn));
    end
  end

  assign out_valid_o      = out_valid_q;
  assign txd_o            = txd_q;
  assign tx_busy_o        = tx_busy_q;
  assign rx_busy_o        = rx_busy_q;
  assign rx_valid_o       = rx_valid_q;
  assign rx_data_o        = rx_data_q;
  assign rx_end_of_line_o = eol_q;

endmodule

[hdl/stut_checker.sv]
// Port-level checker for the shared-timer UART transceiver, bound to the top.
// Depends on stut_pkg and shared_timer_uart_transceiver_defines.svh.
`include "shared_timer_uart_transceiver_defines.svh"

module stut_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        txd_o,
  input logic        tx_busy_o,
  input logic        rx_busy_o,
  input logic        rx_valid_o,
  input logic [7:0]  rx_data_o,
  input logic        rx_end_of_line_o
);

  logic        stalled;
  logic        rx_fields_clear;
  logic        eol_code_ok;
  logic [12:0] held_fields;

  assign stalled         = out_valid_o && !out_ready_i;
  assign rx_fields_clear = (rx_data_o == '0) && !rx_end_of_line_o;
  assign eol_code_ok     = (rx_data_o == stut_pkg::LineFeed) ||
                           (rx_data_o == stut_pkg::CarriageReturn);
  assign held_fields     = {txd_o, tx_busy_o, rx_busy_o, rx_valid_o, rx_data_o,
                            rx_end_of_line_o};

  // an idle transmitter holds the line high
  `STUT_ASSERT(a_txd_idle_high, out_valid_o && !tx_busy_o, txd_o, "txd low while tx idle")

  // no byte means a zero data field and no line flag
  `STUT_ASSERT(a_rx_quiet, out_valid_o && !rx_valid_o, rx_fields_clear, "rx fields without byte")

  // the line flag is only raised for CR or LF
  `STUT_ASSERT(a_eol_code, out_valid_o && rx_end_of_line_o, eol_code_ok, "end of line on other byte")

  // a stalled result stays put
  `STUT_ASSERT_NEXT(a_out_hold, stalled, out_valid_o && $stable(held_fields), "stalled result changed")

endmodule

bind shared_timer_uart_transceiver stut_checker u_stut_checker (.*);
